// ===== design/fdiv_pkg.sv =====
// package for the radix-4 floating point divider
// types, format constants and a packing helper shared by the controller, datapath and top level
`default_nettype none
package fdiv_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned FracW = 52;
  localparam int unsigned SigW  = 53;
  localparam int unsigned RemW  = 55;
  localparam int unsigned QuoW  = 54;
  localparam int unsigned ExpW  = 14;
  localparam int unsigned EfW   = 11;
  localparam int unsigned CntW  = 5;

  // format codes
  localparam logic [1:0] FmtHalf   = 2'd0;
  localparam logic [1:0] FmtSingle = 2'd1;
  localparam logic [1:0] FmtDouble = 2'd2;

  // rounding modes
  localparam logic [1:0] RndNearEven = 2'd0;
  localparam logic [1:0] RndUp       = 2'd1;
  localparam logic [1:0] RndDown     = 2'd2;
  localparam logic [1:0] RndZero     = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CfgRoundMode = 2'd0;
  localparam logic [1:0] CfgFlushZero = 2'd1;
  localparam logic [1:0] CfgDefaultNan = 2'd2;

  typedef struct packed {
    logic load;
    logic unpack;
    logic norm;
    logic pre;
    logic div;
    logic shift;
    logic emit;
    logic emit_special;
  } fdiv_cmd_t;

  typedef struct packed {
    logic            special;
    logic            norm_done;
    logic [CntW-1:0] iters;
  } fdiv_status_t;

  typedef struct packed {
    logic invalid;
    logic div_zero;
    logic overflow;
    logic underflow;
    logic inexact;
    logic in_denormal;
  } fdiv_flags_t;

  // place sign, exponent and left-aligned fraction into a format encoding
  function automatic logic [DataW-1:0] fdiv_pack(input logic [1:0] fmt, input logic s,
                                                 input logic [EfW-1:0] e,
                                                 input logic [FracW-1:0] f);
    logic [DataW-1:0] r;
    unique case (fmt)
      FmtHalf:   r = {48'd0, s, e[4:0], f[51:42]};
      FmtSingle: r = {32'd0, s, e[7:0], f[51:29]};
      default:   r = {s, e, f};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/fdiv_in_if.sv =====
// input channel of the divider: two operand encodings and a format
// depends on nothing
`default_nettype none
interface fdiv_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] dividend;
  logic [63:0] divisor;
  logic [1:0]  precision;
  modport source(output valid, dividend, divisor, precision, input ready);
  modport sink(input valid, dividend, divisor, precision, output ready);
endinterface
`default_nettype wire

// ===== design/fdiv_out_if.sv =====
// result channel of the divider: quotient encoding and six flags
// depends on nothing
`default_nettype none
interface fdiv_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] quotient;
  logic        invalid_flag;
  logic        divide_by_zero_flag;
  logic        overflow_flag;
  logic        underflow_flag;
  logic        inexact_flag;
  logic        input_denormal_flag;
  modport source(output valid, quotient, invalid_flag, divide_by_zero_flag, overflow_flag,
                 underflow_flag, inexact_flag, input_denormal_flag, input ready);
  modport sink(input valid, quotient, invalid_flag, divide_by_zero_flag, overflow_flag,
               underflow_flag, inexact_flag, input_denormal_flag, output ready);
endinterface
`default_nettype wire

// ===== design/fdiv_cfg_if.sv =====
// configuration write channel: register index and write data
// depends on nothing
`default_nettype none
interface fdiv_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/fdiv_datapath.sv =====
// divider datapath: unpack, special cases, normalize, digit recurrence, round
// depends on fdiv_pkg
`default_nettype none
module fdiv_datapath (
  input  wire logic                   clk_i,
  input  wire fdiv_pkg::fdiv_cmd_t    cmd_i,
  output fdiv_pkg::fdiv_status_t      status_o,
  input  wire logic [63:0]            dividend_i,
  input  wire logic [63:0]            divisor_i,
  input  wire logic [1:0]             precision_i,
  input  wire logic [1:0]             round_mode_i,
  input  wire logic                   flush_zero_i,
  input  wire logic                   default_nan_i,
  output logic [63:0]                 quotient_o,
  output fdiv_pkg::fdiv_flags_t       flags_o
);
  import fdiv_pkg::*;

  logic [DataW-1:0]       a_q, b_q;
  logic [1:0]             fmt_q;
  logic                   sign_q;
  logic [SigW-1:0]        siga_q, sigb_q, siga_d, sigb_d;
  logic signed [ExpW-1:0] ea_q, eb_q, ea_d, eb_d, expq_q;
  logic [RemW-1:0]        rem_q;
  logic [QuoW-1:0]        quo_q, gs_q;
  logic                   stk_q, tiny_q, ovf_q;
  logic [DataW-1:0]       quot_q;
  fdiv_flags_t            flags_q;

  // field extraction per format, fractions left aligned
  logic           sa, sb;
  logic [EfW-1:0] ea, eb, emax, bias;
  logic [FracW-1:0] fa, fb;
  always_comb begin
    unique case (fmt_q)
      FmtHalf: begin
        sa = a_q[15]; ea = EfW'(a_q[14:10]); fa = {a_q[9:0], 42'd0};
        sb = b_q[15]; eb = EfW'(b_q[14:10]); fb = {b_q[9:0], 42'd0};
        emax = 11'd31; bias = 11'd15;
      end
      FmtSingle: begin
        sa = a_q[31]; ea = EfW'(a_q[30:23]); fa = {a_q[22:0], 29'd0};
        sb = b_q[31]; eb = EfW'(b_q[30:23]); fb = {b_q[22:0], 29'd0};
        emax = 11'd255; bias = 11'd127;
      end
      default: begin
        sa = a_q[63]; ea = a_q[62:52]; fa = a_q[51:0];
        sb = b_q[63]; eb = b_q[62:52]; fb = b_q[51:0];
        emax = 11'd2047; bias = 11'd1023;
      end
    endcase
  end

  // operand classes
  logic a_max, b_max, a_zf, b_zf, a_ez, b_ez;
  logic a_inf, b_inf, a_snan, b_snan, a_qnan, b_qnan, a_zero, b_zero, a_fin, b_fin;
  logic sign;
  assign a_max  = ea == emax;
  assign b_max  = eb == emax;
  assign a_zf   = fa == '0;
  assign b_zf   = fb == '0;
  assign a_ez   = ea == '0;
  assign b_ez   = eb == '0;
  assign a_inf  = a_max & a_zf;
  assign b_inf  = b_max & b_zf;
  assign a_snan = a_max & ~a_zf & ~fa[FracW-1];
  assign b_snan = b_max & ~b_zf & ~fb[FracW-1];
  assign a_qnan = a_max & ~a_zf & fa[FracW-1];
  assign b_qnan = b_max & ~b_zf & fb[FracW-1];
  assign a_zero = a_ez & (a_zf | flush_zero_i);
  assign b_zero = b_ez & (b_zf | flush_zero_i);
  assign a_fin  = ~a_max & ~a_zero;
  assign b_fin  = ~b_max & ~b_zero;
  assign sign   = sa ^ sb;

  // special operand results
  logic [DataW-1:0] spec_res, def_nan, inf_res, zero_res;
  fdiv_flags_t      spec_flags;
  logic [FracW-1:0] qbit;
  assign qbit     = {1'b1, {(FracW-1){1'b0}}};
  assign def_nan  = fdiv_pack(fmt_q, 1'b0, emax, qbit);
  assign inf_res  = fdiv_pack(fmt_q, sign, emax, '0);
  assign zero_res = fdiv_pack(fmt_q, sign, '0, '0);
  always_comb begin
    spec_flags = '0;
    spec_flags.in_denormal = flush_zero_i & (fmt_q != FmtHalf) &
                             ((a_ez & ~a_zf) | (b_ez & ~b_zf));
    priority if (a_snan) begin
      spec_res = default_nan_i ? def_nan : fdiv_pack(fmt_q, sa, emax, fa | qbit);
      spec_flags.invalid = 1'b1;
    end else if (b_snan) begin
      spec_res = default_nan_i ? def_nan : fdiv_pack(fmt_q, sb, emax, fb | qbit);
      spec_flags.invalid = 1'b1;
    end else if (a_qnan) begin
      spec_res = default_nan_i ? def_nan : fdiv_pack(fmt_q, sa, emax, fa);
    end else if (b_qnan) begin
      spec_res = default_nan_i ? def_nan : fdiv_pack(fmt_q, sb, emax, fb);
    end else if (a_inf) begin
      spec_res = b_inf ? def_nan : inf_res;
      spec_flags.invalid = b_inf;
    end else if (b_inf) begin
      spec_res = zero_res;
    end else if (a_zero) begin
      spec_res = b_zero ? def_nan : zero_res;
      spec_flags.invalid = b_zero;
    end else begin
      spec_res = inf_res;
      spec_flags.div_zero = 1'b1;
    end
  end

  // normalization step: by eight when the top byte is clear, else by one
  always_comb begin
    siga_d = siga_q; ea_d = ea_q;
    sigb_d = sigb_q; eb_d = eb_q;
    if (!siga_q[SigW-1]) begin
      if (siga_q[SigW-1 -: 8] == '0) begin
        siga_d = siga_q << 8; ea_d = ea_q - ExpW'(8);
      end else begin
        siga_d = siga_q << 1; ea_d = ea_q - ExpW'(1);
      end
    end
    if (!sigb_q[SigW-1]) begin
      if (sigb_q[SigW-1 -: 8] == '0) begin
        sigb_d = sigb_q << 8; eb_d = eb_q - ExpW'(8);
      end else begin
        sigb_d = sigb_q << 1; eb_d = eb_q - ExpW'(1);
      end
    end
  end

  // two quotient digits per cycle from the partial remainder
  logic [RemW-1:0] dvs, r1, r2;
  logic            qd1, qd2;
  always_comb begin
    dvs = {2'b00, sigb_q};
    qd1 = rem_q >= dvs;
    r1  = (qd1 ? rem_q - dvs : rem_q) << 1;
    qd2 = r1 >= dvs;
    r2  = (qd2 ? r1 - dvs : r1) << 1;
  end

  // quotient alignment and right shift for tiny results
  logic [QuoW-1:0]        galign;
  logic                   stk_raw, lost, tiny, ovf;
  logic [5:0]             rsh;
  logic signed [ExpW-1:0] neg_e;
  logic [DataW-1:0]       gw;
  always_comb begin
    unique case (fmt_q)
      FmtHalf:   galign = {quo_q[11:0], 42'd0};
      FmtSingle: galign = {quo_q[25:1], 29'd0};
      default:   galign = quo_q;
    endcase
    stk_raw = (rem_q != '0) | ((fmt_q == FmtSingle) & quo_q[0]);
    tiny    = expq_q <= 0;
    ovf     = expq_q >= $signed({3'b000, emax});
    neg_e   = ExpW'(1) - expq_q;
    if (!tiny)                              rsh = '0;
    else if (expq_q < $signed(-ExpW'(61))) rsh = 6'd63;
    else                                    rsh = neg_e[5:0];
    gw   = {10'd0, galign};
    lost = |(gw & ~({DataW{1'b1}} << rsh));
  end

  // rounding of the aligned quotient
  logic             grd, lsb, below, sd, up, maxnorm;
  logic [QuoW-1:0]  trunc, incv;
  logic [RemW-1:0]  rsum;
  logic [DataW-1:0] rnd_res;
  fdiv_flags_t      rnd_flags;
  always_comb begin
    unique case (fmt_q)
      FmtHalf: begin
        grd = gs_q[42]; lsb = gs_q[43]; below = |gs_q[41:0];
        trunc = {gs_q[53:43], 43'd0}; incv = QuoW'(1) << 43;
      end
      FmtSingle: begin
        grd = gs_q[29]; lsb = gs_q[30]; below = |gs_q[28:0];
        trunc = {gs_q[53:30], 30'd0}; incv = QuoW'(1) << 30;
      end
      default: begin
        grd = gs_q[0]; lsb = gs_q[1]; below = 1'b0;
        trunc = {gs_q[53:1], 1'b0}; incv = QuoW'(2);
      end
    endcase
    sd = stk_q | below;
    unique case (round_mode_i)
      RndNearEven: up = grd & (lsb | sd);
      RndUp:       up = ~sign_q & (grd | sd);
      RndDown:     up = sign_q & (grd | sd);
      default:     up = 1'b0;
    endcase
    rsum    = {1'b0, trunc} + (up ? {1'b0, incv} : '0);
    maxnorm = (round_mode_i == RndDown && !sign_q) || (round_mode_i == RndUp && sign_q) ||
              (round_mode_i == RndZero);
    rnd_flags = '0;
    if (ovf_q) begin
      rnd_res = maxnorm ? fdiv_pack(fmt_q, sign_q, emax - EfW'(1), {FracW{1'b1}})
                        : fdiv_pack(fmt_q, sign_q, emax, '0);
      rnd_flags.overflow = 1'b1;
      rnd_flags.inexact  = 1'b1;
    end else if (tiny_q) begin
      if (flush_zero_i) begin
        rnd_res = fdiv_pack(fmt_q, sign_q, '0, '0);
        rnd_flags.underflow = 1'b1;
      end else begin
        rnd_res = fdiv_pack(fmt_q, sign_q, {10'd0, rsum[53]}, rsum[52:1]);
        rnd_flags.underflow = grd | sd;
        rnd_flags.inexact   = grd | sd;
      end
    end else begin
      rnd_res = fdiv_pack(fmt_q, sign_q, expq_q[EfW-1:0], rsum[52:1]);
      rnd_flags.inexact = grd | sd;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q   <= dividend_i;
      b_q   <= divisor_i;
      fmt_q <= precision_i;
    end
    if (cmd_i.unpack) begin
      sign_q <= sign;
      siga_q <= {~a_ez, fa};
      sigb_q <= {~b_ez, fb};
      ea_q   <= a_ez ? ExpW'(1) : $signed({3'b000, ea});
      eb_q   <= b_ez ? ExpW'(1) : $signed({3'b000, eb});
    end
    if (cmd_i.norm) begin
      siga_q <= siga_d; ea_q <= ea_d;
      sigb_q <= sigb_d; eb_q <= eb_d;
    end
    if (cmd_i.pre) begin
      quo_q <= '0;
      if (siga_q < sigb_q) begin
        rem_q  <= {1'b0, siga_q, 1'b0};
        expq_q <= ea_q - eb_q + $signed({3'b000, bias}) - ExpW'(1);
      end else begin
        rem_q  <= {2'b00, siga_q};
        expq_q <= ea_q - eb_q + $signed({3'b000, bias});
      end
    end
    if (cmd_i.div) begin
      rem_q <= r2;
      quo_q <= {quo_q[QuoW-3:0], qd1, qd2};
    end
    if (cmd_i.shift) begin
      gs_q   <= galign >> rsh;
      stk_q  <= stk_raw | lost;
      tiny_q <= tiny;
      ovf_q  <= ovf;
    end
    if (cmd_i.emit) begin
      quot_q  <= cmd_i.emit_special ? spec_res : rnd_res;
      flags_q <= cmd_i.emit_special ? spec_flags : rnd_flags;
    end
  end

  // status toward the controller
  always_comb begin
    status_o.special   = ~(a_fin & b_fin);
    status_o.norm_done = siga_q[SigW-1] & sigb_q[SigW-1];
    unique case (fmt_q)
      FmtHalf:   status_o.iters = CntW'(6);
      FmtSingle: status_o.iters = CntW'(13);
      default:   status_o.iters = CntW'(27);
    endcase
  end

  assign quotient_o = quot_q;
  assign flags_o    = flags_q;

endmodule
`default_nettype wire

// ===== design/fdiv_ctrl.sv =====
// divider controller: sequencing state machine, digit counter, result valid
// depends on fdiv_pkg
`default_nettype none
module fdiv_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  input  wire fdiv_pkg::fdiv_status_t status_i,
  output fdiv_pkg::fdiv_cmd_t         cmd_o
);
  import fdiv_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UNPK  = 3'd1;
  localparam logic [2:0] S_NORM  = 3'd2;
  localparam logic [2:0] S_PRE   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_SHIFT = 3'd5;
  localparam logic [2:0] S_ROUND = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i) state_d = S_UNPK;
      end
      S_UNPK: begin
        cmd_o.unpack = 1'b1;
        if (status_i.special) begin
          if (out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.emit_special = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (status_i.norm_done) state_d = S_PRE;
        else cmd_o.norm = 1'b1;
      end
      S_PRE: begin
        cmd_o.pre = 1'b1;
        cnt_d = status_i.iters - CntW'(1);
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        if (cnt_q == '0) state_d = S_SHIFT;
        else cnt_d = cnt_q - CntW'(1);
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        state_d = S_ROUND;
      end
      S_ROUND: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = cmd_o.emit | (out_valid_q & ~out_ready_i);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // a result is loaded only into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending result");

  // results leave only from unpack or round
  a_emit_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (state_q == S_UNPK || state_q == S_ROUND))
    else $error("result emitted from wrong state");

  // an accepted item goes to unpack next
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == S_UNPK)
    else $error("accepted item not unpacked");

  // digit counter stays below the digit count of the format
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cnt_q < status_i.iters)
    else $error("digit counter out of range");

endmodule
`default_nettype wire

// ===== design/float_divide_srt_radix4.sv =====
// IEEE 754 divider for half, single and double precision.
// Each operand pair takes one item slot; operands with NaN, infinity or zero
// finish from the unpack state. Other operands pass through unpack,
// normalization (steps taken only for subnormal operands), the remainder
// recurrence with 6 radix-4 digits for half, 13 for single and 27 for
// double precision, a shift for tiny results, and rounding. One item is
// in flight at a time; the output register lets the next item enter while a
// result waits. Configuration registers are written through cfg_i
// (index 0 rounding mode, 1 flush to zero, 2 default NaN); the user must write
// them only while the block is idle, which the block itself does not enforce.
// depends on fdiv_pkg, fdiv_in_if, fdiv_out_if, fdiv_cfg_if, fdiv_ctrl,
// fdiv_datapath
`default_nettype none
module float_divide_srt_radix4 (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fdiv_in_if.sink     in_i,
  fdiv_out_if.source  out_o,
  fdiv_cfg_if.sink    cfg_i
);
  import fdiv_pkg::*;

  logic [1:0]   round_mode_q;
  logic         flush_zero_q;
  logic         default_nan_q;
  fdiv_cmd_t    cmd;
  fdiv_status_t status;
  fdiv_flags_t  flags;
  logic         in_ready;
  logic         out_valid;

  // configuration registers
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_mode_q  <= RndNearEven;
      flush_zero_q  <= 1'b0;
      default_nan_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgRoundMode:  round_mode_q  <= cfg_i.data;
        CfgFlushZero:  flush_zero_q  <= cfg_i.data[0];
        CfgDefaultNan: default_nan_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // sequencing
  fdiv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic
  fdiv_datapath u_datapath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .dividend_i    (in_i.dividend),
    .divisor_i     (in_i.divisor),
    .precision_i   (in_i.precision),
    .round_mode_i  (round_mode_q),
    .flush_zero_i  (flush_zero_q),
    .default_nan_i (default_nan_q),
    .quotient_o    (out_o.quotient),
    .flags_o       (flags)
  );

  assign in_i.ready                = in_ready;
  assign out_o.valid               = out_valid;
  assign out_o.invalid_flag        = flags.invalid;
  assign out_o.divide_by_zero_flag = flags.div_zero;
  assign out_o.overflow_flag       = flags.overflow;
  assign out_o.underflow_flag      = flags.underflow;
  assign out_o.inexact_flag        = flags.inexact;
  assign out_o.input_denormal_flag = flags.in_denormal;

endmodule
`default_nettype wire
